[rtl/jbt_pkg.sv]
// Package: shared types, codes and constants for the journal block table
`default_nettype none

package jbt_pkg;

    // Default table depth and fixed field widths
    localparam int JBT_TABLE_DEPTH = 32;
    localparam int BLK_W           = 32;
    localparam int CNT_W           = 6;
    localparam int SLOT_W          = 5;
    localparam int MODE_W          = 3;
    localparam int STATUS_W        = 4;
    localparam int CFG_IDX_W       = 1;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_BEGIN  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_END    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DONE   = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_GRANTED     = 4'd0;
    localparam logic [STATUS_W-1:0] ST_WAIT        = 4'd1;
    localparam logic [STATUS_W-1:0] ST_ENDED       = 4'd2;
    localparam logic [STATUS_W-1:0] ST_COMMIT      = 4'd3;
    localparam logic [STATUS_W-1:0] ST_ABSORBED    = 4'd4;
    localparam logic [STATUS_W-1:0] ST_APPENDED    = 4'd5;
    localparam logic [STATUS_W-1:0] ST_READ        = 4'd6;
    localparam logic [STATUS_W-1:0] ST_CLEARED     = 4'd7;
    localparam logic [STATUS_W-1:0] ST_FULL        = 4'd8;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE     = 4'd9;
    localparam logic [STATUS_W-1:0] ST_COMMITTING  = 4'd10;
    localparam logic [STATUS_W-1:0] ST_NO_COMMIT   = 4'd11;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX   = 4'd12;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_LIMIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OP_RESERVE = 1'd1;

    // Largest open-operation count before begin saturates
    localparam logic [CNT_W-1:0] OPEN_MAX = 6'd63;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [BLK_W-1:0]   block_number;
        logic [SLOT_W-1:0]  entry_index;
    } jbt_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [BLK_W-1:0]    block_out;
        logic [CNT_W-1:0]    entry_count;
        logic [CNT_W-1:0]    open_ops;
    } jbt_out_t;

    typedef struct packed {
        logic [CNT_W-1:0] log_limit;
        logic [CNT_W-1:0] op_reserve;
    } jbt_cfg_t;

    typedef enum logic [1:0] {
        JBT_IDLE,
        JBT_SEARCH,
        JBT_READ,
        JBT_RESP
    } jbt_state_t;

endpackage

`default_nettype wire

[rtl/jbt_ram.sv]
// Block number table: single write port, registered read port
`default_nettype none

module jbt_ram #(
    parameter int TABLE_DEPTH = jbt_pkg::JBT_TABLE_DEPTH,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [AW-1:0]            waddr,
    input  wire logic [jbt_pkg::BLK_W-1:0] wdata,
    input  wire logic [AW-1:0]            raddr,
    output logic      [jbt_pkg::BLK_W-1:0] rdata
);
    import jbt_pkg::*;

    logic [BLK_W-1:0] mem [TABLE_DEPTH];

    // Write the appended block number
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read of the addressed entry
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/jbt_ctrl.sv]
// Request sequencer: admission counters, table search and result register
`default_nettype none

module jbt_ctrl #(
    parameter int TABLE_DEPTH = jbt_pkg::JBT_TABLE_DEPTH,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire jbt_pkg::jbt_cfg_t         cfg,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire jbt_pkg::jbt_in_t          s_data,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output jbt_pkg::jbt_out_t              m_data,
    output logic                           ram_we,
    output logic [AW-1:0]                  ram_waddr,
    output logic [jbt_pkg::BLK_W-1:0]      ram_wdata,
    output logic [AW-1:0]                  ram_raddr,
    input  wire logic [jbt_pkg::BLK_W-1:0] ram_rdata
);
    import jbt_pkg::*;

    localparam logic [CNT_W:0] DEPTH_X = (CNT_W+1)'(TABLE_DEPTH);
    localparam int             NEED_W  = 2*CNT_W + 1;

    jbt_state_t       state_reg, state_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] open_reg, open_next;
    logic             commit_reg, commit_next;
    logic [BLK_W-1:0] blk_reg, blk_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             pend_reg, pend_next;
    jbt_out_t         res_reg, res_next;
    logic             m_valid_reg, m_valid_next;
    jbt_out_t         m_data_reg, m_data_next;

    logic [CNT_W:0]    lim;
    logic [NEED_W-1:0] need;
    logic              hit;
    logic              last_cmp;

    // Effective limit and admission demand
    always_comb begin
        lim  = ({1'b0, cfg.log_limit} < DEPTH_X) ? {1'b0, cfg.log_limit} : DEPTH_X;
        need = NEED_W'(used_reg) +
               NEED_W'((CNT_W+1)'(open_reg) + (CNT_W+1)'(1)) * NEED_W'(cfg.op_reserve);
        hit      = pend_reg && (ram_rdata == blk_reg);
        last_cmp = pend_reg && (cmp_idx_reg == used_reg - CNT_W'(1));
    end

    // Next state and outputs
    always_comb begin
        state_next   = state_reg;
        used_next    = used_reg;
        open_next    = open_reg;
        commit_next  = commit_reg;
        blk_next     = blk_reg;
        rd_idx_next  = rd_idx_reg;
        cmp_idx_next = cmp_idx_reg;
        pend_next    = pend_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        s_ready      = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = used_reg[AW-1:0];
        ram_wdata    = blk_reg;
        ram_raddr    = rd_idx_reg[AW-1:0];

        // Drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            JBT_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    blk_next              = s_data.block_number;
                    res_next              = '0;
                    res_next.status       = ST_OUTSIDE;
                    state_next            = JBT_RESP;
                    case (s_data.mode)
                        MODE_BEGIN: begin
                            if (commit_reg || open_reg == OPEN_MAX) begin
                                res_next.status = ST_WAIT;
                            end else if (need > NEED_W'(lim)) begin
                                res_next.status = ST_WAIT;
                            end else begin
                                open_next       = open_reg + CNT_W'(1);
                                res_next.status = ST_GRANTED;
                            end
                        end
                        MODE_END: begin
                            if (commit_reg) begin
                                res_next.status = ST_COMMITTING;
                            end else if (open_reg == '0) begin
                                res_next.status = ST_OUTSIDE;
                            end else begin
                                open_next = open_reg - CNT_W'(1);
                                if (open_reg == CNT_W'(1)) begin
                                    commit_next     = 1'b1;
                                    res_next.status = ST_COMMIT;
                                end else begin
                                    res_next.status = ST_ENDED;
                                end
                            end
                        end
                        MODE_WRITE: begin
                            if ({1'b0, used_reg} >= lim) begin
                                res_next.status = ST_FULL;
                            end else if (open_reg == '0) begin
                                res_next.status = ST_OUTSIDE;
                            end else begin
                                rd_idx_next = '0;
                                pend_next   = 1'b0;
                                state_next  = JBT_SEARCH;
                            end
                        end
                        MODE_READ: begin
                            if (!commit_reg) begin
                                res_next.status = ST_NO_COMMIT;
                            end else if ((CNT_W+1)'(s_data.entry_index) >=
                                             {1'b0, used_reg} ||
                                         (CNT_W+1)'(s_data.entry_index) >= DEPTH_X) begin
                                res_next.status = ST_BAD_INDEX;
                            end else begin
                                ram_raddr       = AW'(s_data.entry_index);
                                res_next.status = ST_READ;
                                res_next.slot   = s_data.entry_index;
                                state_next      = JBT_READ;
                            end
                        end
                        MODE_DONE: begin
                            if (!commit_reg) begin
                                res_next.status = ST_NO_COMMIT;
                            end else begin
                                used_next       = '0;
                                commit_next     = 1'b0;
                                res_next.status = ST_CLEARED;
                            end
                        end
                        default: begin
                            res_next.status = ST_OUTSIDE;
                        end
                    endcase
                end
            end

            JBT_SEARCH: begin
                // Issue the next read while the previous entry is compared
                if (rd_idx_reg < used_reg) begin
                    pend_next    = 1'b1;
                    cmp_idx_next = rd_idx_reg;
                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                end else begin
                    pend_next = 1'b0;
                end
                if (hit) begin
                    res_next.status = ST_ABSORBED;
                    res_next.slot   = cmp_idx_reg[SLOT_W-1:0];
                    state_next      = JBT_RESP;
                end else if (last_cmp || (!pend_reg && rd_idx_reg >= used_reg)) begin
                    ram_we          = 1'b1;
                    used_next       = used_reg + CNT_W'(1);
                    res_next.status = ST_APPENDED;
                    res_next.slot   = used_reg[SLOT_W-1:0];
                    state_next      = JBT_RESP;
                end
            end

            JBT_READ: begin
                res_next.block_out = ram_rdata;
                state_next         = JBT_RESP;
            end

            JBT_RESP: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next             = res_reg;
                    m_data_next.entry_count = used_reg;
                    m_data_next.open_ops    = open_reg;
                    state_next              = JBT_IDLE;
                end
            end

            default: begin
                state_next = JBT_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= JBT_IDLE;
            used_reg    <= '0;
            open_reg    <= '0;
            commit_reg  <= 1'b0;
            pend_reg    <= 1'b0;
            rd_idx_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            open_reg    <= open_next;
            commit_reg  <= commit_next;
            pend_reg    <= pend_next;
            rd_idx_reg  <= rd_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        blk_reg     <= blk_next;
        cmp_idx_reg <= cmp_idx_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

[rtl/journal_block_table_with_admission.sv]
// Top level: journal admission and block absorption table
//
//  Port group   Direction  Contents
//  s_*          in         request: mode, block_number, entry_index
//  m_*          out        result: status, slot, block_out, entry_count, open_ops
//  cfg_*        in         register write: cfg_index, cfg_data (always ready)
//
//  Begin, end, commit done and bad requests go from the result register to the output register.
//  Read entry adds one table read through the registered memory port.
//  Record write searches the occupied entries, reading one table entry per cycle; an
//  absorb ends early, at the matching slot.
//  One request is in flight at a time; a stalled result holds in the output register.
//  Reset clears the counters and commit flag; the table needs no clearing pass.
`default_nettype none

module journal_block_table_with_admission #(
    parameter int TABLE_DEPTH = jbt_pkg::JBT_TABLE_DEPTH
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire jbt_pkg::jbt_in_t              s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output jbt_pkg::jbt_out_t                  m_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [jbt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [jbt_pkg::CNT_W-1:0]     cfg_data
);
    import jbt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    jbt_cfg_t         cfg_reg;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [BLK_W-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [BLK_W-1:0] ram_rdata;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.log_limit  <= CNT_W'(30);
            cfg_reg.op_reserve <= CNT_W'(10);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_LOG_LIMIT:  cfg_reg.log_limit  <= cfg_data;
                CFG_OP_RESERVE: cfg_reg.op_reserve <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    jbt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    jbt_ram #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

[sim/journal_block_table_with_admission_test.sv]
// Testbench for the journal admission and block absorption table
`timescale 1ns / 1ps

module journal_block_table_with_admission_test;
    import jbt_pkg::*;

    localparam int ITEMS_TARGET  = 1400;
    localparam int QUIET_FROM    = 1250;
    localparam int PHASE_ITEMS   = 140;
    localparam int HOLD_AT       = 300;
    localparam int PAUSE_AT      = 700;
    localparam int HOLD_CYCLES   = 120;
    localparam int DRAIN_CYCLES  = 40;
    localparam int TAIL_CYCLES   = 60;
    localparam int STALL_LIMIT   = 2000;
    localparam int N_PLAN        = 8;

    // Register values after reset
    localparam logic [CNT_W-1:0] LIMIT_AT_RESET   = 6'd30;
    localparam logic [CNT_W-1:0] RESERVE_AT_RESET = 6'd10;

    // Modes the block does not define
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    // Register settings walked through by the random phases
    logic [CNT_W-1:0] limit_plan   [N_PLAN] = '{6'd30, 6'd32, 6'd1, 6'd32,
                                                6'd12, 6'd5, 6'd20, 6'd1};
    logic [CNT_W-1:0] reserve_plan [N_PLAN] = '{6'd10, 6'd1, 6'd1, 6'd32,
                                                6'd3, 6'd1, 6'd4, 6'd32};

    // Shadow of the journal table: works out the result of every request
    class journal_scoreboard;
        logic [BLK_W-1:0] blocks [JBT_TABLE_DEPTH];
        logic [CNT_W-1:0] used_cnt;
        logic [CNT_W-1:0] open_cnt;
        logic             committing;
        logic [CNT_W-1:0] limit_reg;
        logic [CNT_W-1:0] reserve_reg;
        jbt_out_t         awaited [$];
        int               errors;

        function new();
            foreach (blocks[i]) blocks[i] = '0;
            used_cnt    = '0;
            open_cnt    = '0;
            committing  = 1'b0;
            limit_reg   = LIMIT_AT_RESET;
            reserve_reg = RESERVE_AT_RESET;
            errors      = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
            case (idx)
                CFG_LOG_LIMIT:  limit_reg = val;
                CFG_OP_RESERVE: reserve_reg = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Apply one accepted request and queue the result it must give
        function void note(jbt_in_t req);
            jbt_out_t want;
            int       lim;
            int       hit;
            want = '0;
            lim  = (int'(limit_reg) < JBT_TABLE_DEPTH) ? int'(limit_reg) : JBT_TABLE_DEPTH;
            case (req.mode)
                MODE_BEGIN: begin
                    if (committing || open_cnt >= OPEN_MAX) begin
                        want.status = ST_WAIT;
                    end else if (int'(used_cnt) + (int'(open_cnt) + 1) * int'(reserve_reg)
                                 > lim) begin
                        want.status = ST_WAIT;
                    end else begin
                        open_cnt++;
                        want.status = ST_GRANTED;
                    end
                end
                MODE_END: begin
                    if (committing) begin
                        want.status = ST_COMMITTING;
                    end else if (open_cnt == 0) begin
                        want.status = ST_OUTSIDE;
                    end else begin
                        open_cnt--;
                        if (open_cnt == 0) begin
                            committing  = 1'b1;
                            want.status = ST_COMMIT;
                        end else begin
                            want.status = ST_ENDED;
                        end
                    end
                end
                MODE_WRITE: begin
                    if (int'(used_cnt) >= lim) begin
                        want.status = ST_FULL;
                    end else if (open_cnt == 0) begin
                        want.status = ST_OUTSIDE;
                    end else begin
                        // search the occupied slots, oldest first
                        hit = -1;
                        for (int i = 0; i < int'(used_cnt); i++) begin
                            if (hit < 0 && blocks[i] == req.block_number) hit = i;
                        end
                        if (hit >= 0) begin
                            want.status = ST_ABSORBED;
                            want.slot   = SLOT_W'(hit);
                        end else begin
                            blocks[used_cnt] = req.block_number;
                            want.slot        = used_cnt[SLOT_W-1:0];
                            used_cnt++;
                            want.status      = ST_APPENDED;
                        end
                    end
                end
                MODE_READ: begin
                    if (!committing) begin
                        want.status = ST_NO_COMMIT;
                    end else if (CNT_W'(req.entry_index) >= used_cnt) begin
                        want.status = ST_BAD_INDEX;
                    end else begin
                        want.status    = ST_READ;
                        want.slot      = req.entry_index;
                        want.block_out = blocks[req.entry_index];
                    end
                end
                MODE_DONE: begin
                    if (!committing) begin
                        want.status = ST_NO_COMMIT;
                    end else begin
                        used_cnt    = '0;
                        committing  = 1'b0;
                        want.status = ST_CLEARED;
                    end
                end
                default: want.status = ST_OUTSIDE;
            endcase
            want.entry_count = used_cnt;
            want.open_ops    = open_cnt;
            awaited.push_back(want);
        endfunction

        task report(string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            errors++;
        endtask

        // Compare one delivered result with the oldest outstanding one
        task check(jbt_out_t got);
            jbt_out_t want;
            if (awaited.size() == 0) begin
                report($sformatf("result with nothing outstanding, status %0d", got.status));
            end else begin
                want = awaited.pop_front();
                if (got.status !== want.status)
                    report($sformatf("status %0d, wanted %0d", got.status, want.status));
                if (got.slot !== want.slot)
                    report($sformatf("slot %0d, wanted %0d", got.slot, want.slot));
                if (got.block_out !== want.block_out)
                    report($sformatf("block_out %h, wanted %h", got.block_out,
                                     want.block_out));
                if (got.entry_count !== want.entry_count)
                    report($sformatf("entry_count %0d, wanted %0d", got.entry_count,
                                     want.entry_count));
                if (got.open_ops !== want.open_ops)
                    report($sformatf("open_ops %0d, wanted %0d", got.open_ops,
                                     want.open_ops));
            end
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    jbt_in_t              s_data;
    logic                 m_valid;
    logic                 m_ready;
    jbt_out_t             m_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CNT_W-1:0]     cfg_data;

    journal_scoreboard sb;
    int                items;
    int                stall_cycles;
    bit                quiet;
    bit                long_hold;

    journal_block_table_with_admission dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic jbt_in_t make_req(logic [MODE_W-1:0] mode, logic [BLK_W-1:0] blk,
                                         logic [SLOT_W-1:0] idx);
        jbt_in_t req;
        req.mode         = mode;
        req.block_number = blk;
        req.entry_index  = idx;
        return req;
    endfunction

    // Offer one request and hold it until accepted; returns on a falling edge
    task automatic send(input jbt_in_t req);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        sb.note(req);
        if (req.mode <= MODE_DONE) items++;
        @(negedge aclk);
    endtask

    // Drop the request line and wait until every result is back
    task automatic settle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge aclk);
    endtask

    task automatic apply_setting(input logic [CNT_W-1:0] lim, input logic [CNT_W-1:0] res);
        settle();
        write_reg(CFG_LOG_LIMIT, lim);
        write_reg(CFG_OP_RESERVE, res);
        cfg_valid <= 1'b0;
    endtask

    // One transaction group: begins, record writes, ends, readout, commit done
    task automatic run_group();
        logic [BLK_W-1:0] written [$];
        logic [BLK_W-1:0] blk;
        logic [SLOT_W-1:0] idx;
        int n_wr;
        int guard;
        repeat ($urandom_range(1, 4))
            send(make_req(MODE_BEGIN, $urandom, SLOT_W'($urandom_range(0, 31))));
        n_wr = ($urandom_range(0, 6) == 0) ? $urandom_range(20, 36) : $urandom_range(0, 8);
        for (int k = 0; k < n_wr; k++) begin
            // reuse an earlier block now and then so that it gets absorbed
            if (written.size() > 0 && $urandom_range(0, 2) == 0) begin
                blk = written[$urandom_range(0, written.size() - 1)];
            end else begin
                blk = $urandom;
                written.push_back(blk);
            end
            if ($urandom_range(0, 9) == 0)
                send(make_req(MODE_BEGIN, $urandom, SLOT_W'($urandom_range(0, 31))));
            send(make_req(MODE_WRITE, blk, SLOT_W'($urandom_range(0, 31))));
        end
        // close every open operation; the last one starts the commit
        guard = 0;
        do begin
            send(make_req(MODE_END, $urandom, SLOT_W'($urandom_range(0, 31))));
            guard++;
        end while (sb.open_cnt != 0 && guard < 40);
        repeat ($urandom_range(0, 4)) begin
            if (sb.used_cnt != 0 && $urandom_range(0, 4) != 0)
                idx = SLOT_W'($urandom_range(0, int'(sb.used_cnt) - 1));
            else
                idx = SLOT_W'($urandom_range(0, 31));
            send(make_req(MODE_READ, $urandom, idx));
        end
        if ($urandom_range(0, 9) != 0)
            send(make_req(MODE_DONE, $urandom, SLOT_W'($urandom_range(0, 31))));
    endtask

    task automatic make_noise();
        repeat ($urandom_range(1, 5))
            send(make_req(MODE_W'($urandom_range(0, 7)), $urandom,
                          SLOT_W'($urandom_range(0, 31))));
    endtask

    // Stimulus
    initial begin
        int next_phase;
        int phase;
        bit hold_done;
        bit pause_done;
        sb         = new();
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        items      = 0;
        quiet      = 1'b0;
        long_hold  = 1'b0;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        phase      = 0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // requests that find nothing to act on
        send(make_req(MODE_READ, '0, '0));
        send(make_req(MODE_DONE, '0, '0));
        send(make_req(MODE_END, '0, '0));
        send(make_req(MODE_WRITE, '1, '1));
        send(make_req(MODE_SPARE_LO, '1, '1));
        send(make_req(MODE_SPARE_HI, '0, '0));
        // admission up to the log limit, then a refused begin
        repeat (4) send(make_req(MODE_BEGIN, '0, '0));
        // append, append, absorb at the extremes of the block number
        send(make_req(MODE_WRITE, '0, '0));
        send(make_req(MODE_WRITE, '1, '0));
        send(make_req(MODE_WRITE, '0, '1));
        repeat (3) send(make_req(MODE_END, '0, '0));
        // during the commit: refused begin and end, a good and a bad read, then commit done
        send(make_req(MODE_BEGIN, '0, '0));
        send(make_req(MODE_END, '0, '0));
        send(make_req(MODE_READ, '0, 5'd1));
        send(make_req(MODE_READ, '1, '1));
        send(make_req(MODE_DONE, '0, '0));
        // a one-entry group runs into a full table
        apply_setting(6'd1, 6'd1);
        send(make_req(MODE_BEGIN, '0, '0));
        send(make_req(MODE_WRITE, 32'h0000_0001, '0));
        send(make_req(MODE_WRITE, 32'h8000_0000, '0));
        send(make_req(MODE_END, '0, '0));
        send(make_req(MODE_DONE, '0, '0));

        // random groups and noise under a series of register settings
        next_phase = items;
        while (items < ITEMS_TARGET) begin
            if (items >= next_phase) begin
                if (phase < N_PLAN)
                    apply_setting(limit_plan[phase], reserve_plan[phase]);
                else
                    apply_setting(CNT_W'($urandom_range(1, 32)), CNT_W'($urandom_range(1, 6)));
                phase++;
                next_phase += PHASE_ITEMS;
            end
            if (!hold_done && items >= HOLD_AT) begin
                long_hold = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && items >= PAUSE_AT) begin
                settle();
                pause_done = 1'b1;
            end
            if (items >= QUIET_FROM) quiet = 1'b1;
            if ($urandom_range(0, 4) == 0) make_noise();
            else run_group();
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("journal_block_table_with_admission_test OK");
        else
            $display("journal_block_table_with_admission_test NOT OK");
        $finish;
    end

    // Result side: random stall bursts and one long hold-off
    initial begin : result_sink
        int gap;
        gap     = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                long_hold = 1'b0;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                gap--;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                gap = $urandom_range(1, 3) - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Check each delivered result
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check(m_data);
    end

    // End the run when no handshake completes for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("journal_block_table_with_admission_test NOT OK");
            $finish;
        end
    end

endmodule

[files.f]
rtl/jbt_pkg.sv
rtl/jbt_ram.sv
rtl/jbt_ctrl.sv
rtl/journal_block_table_with_admission.sv
sim/journal_block_table_with_admission_test.sv
